@@ design/h2b_pkg.sv @@
// Package for the hex to base64url encoder: command and result types,
// error codes and the sextet character table. No dependencies.
`timescale 1ns / 1ps

package h2b_pkg;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_EMPTY   = 2'd1;
    localparam logic [1:0] ERR_INVALID = 2'd2;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_END,
        CMD_ERR,
        CMD_EMPTY
    } t_cmd_kind;

    // One parsed event handed from the front to the back.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte_val;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       end_flag;
        logic [1:0] error_code;
    } t_result;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] ch;
        case (v) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         ch = 8'h2D;
            default:       ch = 8'h5F;
        endcase
        return ch;
    endfunction

    function automatic t_result sextet_result(input logic [5:0] v);
        t_result r;
        r.out_char   = sextet_char(v);
        r.char_valid = 1'b1;
        r.end_flag   = 1'b0;
        r.error_code = ERR_OK;
        return r;
    endfunction

    function automatic t_result flag_result(input logic [1:0] code);
        t_result r;
        r.out_char   = 8'h00;
        r.char_valid = 1'b0;
        r.end_flag   = 1'b1;
        r.error_code = code;
        return r;
    endfunction

endpackage

@@ design/h2b_front.sv @@
// Front end: classifies each character, pairs hex digits into bytes and
// tracks whitespace and fault state. Depends on h2b_pkg.
`timescale 1ns / 1ps

module h2b_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_hex_char,
    input  logic          i_odd_count,
    input  logic          i_last,
    output logic          o_cmd_push,
    output h2b_pkg::t_cmd o_cmd
);
    import h2b_pkg::*;

    logic [3:0] r_high_nibble, n_high_nibble;
    logic       r_pending, n_pending;
    logic       r_digits_seen, n_digits_seen;
    logic       r_trailing, n_trailing;
    logic       r_swallow, n_swallow;

    logic       is_space;
    logic       is_dec;
    logic       is_alpha;
    logic [3:0] digit;
    logic       have_byte;
    logic [7:0] byte_val;

    always_comb begin
        is_space = (i_hex_char == 8'h20) || (i_hex_char inside {[8'h09:8'h0D]});
        is_dec   = i_hex_char inside {[8'h30:8'h39]};
        is_alpha = (i_hex_char inside {[8'h61:8'h66]}) || (i_hex_char inside {[8'h41:8'h46]});
        digit    = is_dec ? i_hex_char[3:0] : (i_hex_char[3:0] + 4'd9);
    end

    always_comb begin
        n_high_nibble = r_high_nibble;
        n_pending     = r_pending;
        n_digits_seen = r_digits_seen;
        n_trailing    = r_trailing;
        n_swallow     = r_swallow;
        o_cmd_push    = 1'b0;
        o_cmd.kind    = CMD_END;
        o_cmd.last    = i_last;
        have_byte     = 1'b0;
        byte_val      = {r_high_nibble, digit};
        if (i_take) begin
            if (r_swallow) begin
                // drop everything up to the end of the string
            end else if (is_space) begin
                if (r_digits_seen) begin
                    n_trailing = 1'b1;
                end
                if (i_last) begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = r_digits_seen ? CMD_END : CMD_EMPTY;
                end
            end else if (!(is_dec || is_alpha) || r_trailing) begin
                o_cmd_push = 1'b1;
                o_cmd.kind = CMD_ERR;
                n_swallow  = 1'b1;
            end else begin
                if (!r_digits_seen) begin
                    n_digits_seen = 1'b1;
                    if (i_odd_count) begin
                        have_byte = 1'b1;
                        byte_val  = {4'h0, digit};
                    end else begin
                        n_high_nibble = digit;
                        n_pending     = 1'b1;
                    end
                end else if (r_pending) begin
                    n_pending = 1'b0;
                    have_byte = 1'b1;
                end else begin
                    n_high_nibble = digit;
                    n_pending     = 1'b1;
                end
                if (have_byte || i_last) begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = have_byte ? CMD_BYTE : CMD_END;
                end
            end
            if (i_last) begin
                n_high_nibble = 4'h0;
                n_pending     = 1'b0;
                n_digits_seen = 1'b0;
                n_trailing    = 1'b0;
                n_swallow     = 1'b0;
            end
        end
        o_cmd.byte_val = byte_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_nibble <= 4'h0;
            r_pending     <= 1'b0;
            r_digits_seen <= 1'b0;
            r_trailing    <= 1'b0;
            r_swallow     <= 1'b0;
        end else begin
            r_high_nibble <= n_high_nibble;
            r_pending     <= n_pending;
            r_digits_seen <= n_digits_seen;
            r_trailing    <= n_trailing;
            r_swallow     <= n_swallow;
        end
    end

endmodule

@@ design/h2b_cmd_queue.sv @@
// Two-entry command queue between front and back.
// Depends on h2b_pkg.
`timescale 1ns / 1ps

module h2b_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  h2b_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output h2b_pkg::t_cmd o_head
);
    import h2b_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ design/h2b_back.sv @@
// Back end: expands byte commands into base64url sextets, flushes partial
// groups and holds results in a two-entry output queue. Depends on h2b_pkg.
`timescale 1ns / 1ps

module h2b_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  h2b_pkg::t_cmd i_head,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_char,
    output logic          o_char_valid,
    output logic          o_end_flag,
    output logic [1:0]    o_error_code
);
    import h2b_pkg::*;

    logic [1:0] r_group_pos, n_group_pos;
    logic [3:0] r_carry, n_carry;
    logic       r_phase;

    t_result    res0;
    t_result    res1;
    t_result    res_sel;
    logic       two;
    logic       emit;
    logic [7:0] b;

    t_result    r_oq [2];
    logic       r_oq_wr;
    logic       r_oq_rd;
    logic [1:0] r_oq_count;
    logic       oq_full;
    logic       oq_pop;

    always_comb begin
        b           = i_head.byte_val;
        res0        = flag_result(ERR_OK);
        res1        = flag_result(ERR_OK);
        two         = 1'b0;
        n_group_pos = 2'd0;
        n_carry     = 4'h0;
        case (i_head.kind)
            CMD_ERR: begin
                res0 = flag_result(ERR_INVALID);
            end
            CMD_EMPTY: begin
                res0 = flag_result(ERR_EMPTY);
            end
            CMD_END: begin
                case (r_group_pos)
                    2'd1: begin
                        res0          = sextet_result({r_carry[1:0], 4'h0});
                        res0.end_flag = 1'b1;
                    end
                    2'd2: begin
                        res0          = sextet_result({r_carry, 2'b00});
                        res0.end_flag = 1'b1;
                    end
                    default: begin
                        res0 = flag_result(ERR_OK);
                    end
                endcase
            end
            default: begin
                case (r_group_pos)
                    2'd1: begin
                        res0        = sextet_result({r_carry[1:0], b[7:4]});
                        res1        = sextet_result({b[3:0], 2'b00});
                        two         = i_head.last;
                        n_group_pos = 2'd2;
                        n_carry     = b[3:0];
                    end
                    2'd2: begin
                        res0        = sextet_result({r_carry, b[7:6]});
                        res1        = sextet_result(b[5:0]);
                        two         = 1'b1;
                    end
                    default: begin
                        res0        = sextet_result(b[7:2]);
                        res1        = sextet_result({b[1:0], 4'h0});
                        two         = i_head.last;
                        n_group_pos = 2'd1;
                        n_carry     = {2'b00, b[1:0]};
                    end
                endcase
                if (i_head.last) begin
                    res1.end_flag = 1'b1;
                    n_group_pos   = 2'd0;
                    n_carry       = 4'h0;
                end
            end
        endcase
    end

    // one result per beat unless oq_full; two-result commands hold the head for both
    assign oq_full   = (r_oq_count == 2'd2);
    assign emit      = !i_cmd_empty && !oq_full;
    assign o_cmd_pop = emit && (r_phase || !two);
    assign res_sel   = r_phase ? res1 : res0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_pos <= 2'd0;
            r_carry     <= 4'h0;
            r_phase     <= 1'b0;
        end else if (o_cmd_pop) begin
            r_group_pos <= n_group_pos;
            r_carry     <= n_carry;
            r_phase     <= 1'b0;
        end else if (emit) begin
            r_phase     <= 1'b1;
        end
    end

    assign o_empty      = (r_oq_count == 2'd0);
    assign oq_pop       = i_pop && !o_empty;
    assign o_out_char   = r_oq[r_oq_rd].out_char;
    assign o_char_valid = r_oq[r_oq_rd].char_valid;
    assign o_end_flag   = r_oq[r_oq_rd].end_flag;
    assign o_error_code = r_oq[r_oq_rd].error_code;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oq[r_oq_wr] <= res_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= 1'b0;
            r_oq_rd    <= 1'b0;
            r_oq_count <= 2'd0;
        end else begin
            if (emit) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (oq_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
            r_oq_count <= r_oq_count + {1'b0, emit} - {1'b0, oq_pop};
        end
    end

endmodule

@@ design/hex_to_base64url_encoder.sv @@
// Top level of the hex to base64url encoder: front parser, command queue
// and back encoder. Depends on h2b_pkg, h2b_front, h2b_cmd_queue, h2b_back.
//
//   channel   handshake          fields
//   input     push / full        i_hex_char, i_odd_count, i_last
//   result    empty / pop        o_out_char, o_char_valid, o_end_flag, o_error_code
//
// One character is taken per cycle while full is low. The back encoder writes one
// result per cycle into the output queue when a command waits and the queue has
// room, so a two-result command stays at the head of the two-entry command queue
// until both are written. Commands and results are registered in their queues.
// Reset is synchronous and clears both queues and all parse and group state.
// Either side may stall: full rises when the command queue holds two commands.
`timescale 1ns / 1ps

module hex_to_base64url_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_hex_char,
    input  logic       i_odd_count,
    input  logic       i_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_end_flag,
    output logic [1:0] o_error_code
);
    import h2b_pkg::*;

    logic take;
    logic cmd_push;
    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_head;

    assign take = push && !full;

    h2b_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_hex_char  (i_hex_char),
        .i_odd_count (i_odd_count),
        .i_last      (i_last),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd)
    );

    h2b_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    h2b_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (cmd_empty),
        .i_head       (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_end_flag   (o_end_flag),
        .o_error_code (o_error_code)
    );

endmodule
